// ===== rtl/core/masked_byte_pattern_scan_assert.svh =====
// Assertion macros shared by the scan block.
`ifndef MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH
`define MASKED_BYTE_PATTERN_SCAN_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check on every clock edge outside reset.
`define MBPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Check on every clock edge, reset included.
`define MBPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBPS_ASSERT(lbl, prop, msg)
`define MBPS_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ===== rtl/core/mbps_pkg.sv =====
package mbps_pkg;

  localparam int PATTERN_MAX_DEF = 48;
  localparam int OFFSET_BITS_DEF = 32;

  localparam int OFFSET_W    = 32;
  localparam int SEEN_W      = 33;
  localparam int QUEUE_DEPTH = 2;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int CARE_W      = 48;
  localparam int LEN_CFG_W   = 6;
  localparam int PAT_WORDS   = 6;

  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_A = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_B = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_C = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_D = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_E = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_F = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_CARE      = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_LENGTH    = 3'd7;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] match_offset;
  } result_t;

endpackage

// ===== rtl/core/masked_byte_pattern_scan.sv =====
// Channel   Direction  Handshake         Payload
// input     in         push / full       data_byte, last_byte
// result    out        empty / pop       found, match_offset
// config    in         cfg_valid/ready   cfg_index, cfg_data
//
// One region byte is taken every cycle while full is low; all window positions compare at once.
// The edge that takes a byte queues its result; the output register loads it once free or popped.
// full rises only when the two-entry result queue and the output register are
// all occupied and pop is held low.
// Synchronous rst restores register defaults and starts a new region at once.
// cfg_ready is always high; a write takes effect for the next byte.
module masked_byte_pattern_scan #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               push,
  output logic                               full,
  input  logic [7:0]                         data_byte,
  input  logic                               last_byte,
  output logic                               empty,
  input  logic                               pop,
  output logic                               found,
  output logic [mbps_pkg::OFFSET_W-1:0]      match_offset,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mbps_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [mbps_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int LEN_W = $clog2(PATTERN_MAX + 1);
  localparam int DW    = mbps_pkg::CFG_DATA_W;

  logic [DW-1:0]                  pat_a, pat_b, pat_c, pat_d, pat_e, pat_f;
  logic [mbps_pkg::CARE_W-1:0]    care_mask;
  logic [mbps_pkg::LEN_CFG_W-1:0] pattern_length;

  logic [mbps_pkg::PAT_WORDS*DW-1:0] pattern_all;
  logic [LEN_W-1:0]                  len_eff;
  logic                              accept;
  logic                              res_push, head_valid, take;
  mbps_pkg::result_t                 res_data, head_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_a          <= '0;
      pat_b          <= '0;
      pat_c          <= '0;
      pat_d          <= '0;
      pat_e          <= '0;
      pat_f          <= '0;
      care_mask      <= '0;
      pattern_length <= mbps_pkg::LEN_CFG_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mbps_pkg::REG_PATTERN_A: pat_a <= cfg_data;
        mbps_pkg::REG_PATTERN_B: pat_b <= cfg_data;
        mbps_pkg::REG_PATTERN_C: pat_c <= cfg_data;
        mbps_pkg::REG_PATTERN_D: pat_d <= cfg_data;
        mbps_pkg::REG_PATTERN_E: pat_e <= cfg_data;
        mbps_pkg::REG_PATTERN_F: pat_f <= cfg_data;
        mbps_pkg::REG_CARE:      care_mask <= cfg_data[mbps_pkg::CARE_W-1:0];
        mbps_pkg::REG_LENGTH:    pattern_length <= cfg_data[mbps_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  assign pattern_all = {pat_f, pat_e, pat_d, pat_c, pat_b, pat_a};

  // Zero length acts as one, overlong lengths clamp to the window size.
  always_comb begin
    if (pattern_length == '0) begin
      len_eff = LEN_W'(1);
    end else if (int'(pattern_length) > PATTERN_MAX) begin
      len_eff = LEN_W'(PATTERN_MAX);
    end else begin
      len_eff = LEN_W'(pattern_length);
    end
  end

  assign accept = push && !full;

  mbps_front #(
    .PATTERN_MAX(PATTERN_MAX),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .pattern  (pattern_all[PATTERN_MAX*8-1:0]),
    .care     (care_mask[PATTERN_MAX-1:0]),
    .len      (len_eff),
    .res_push (res_push),
    .res_data (res_data)
  );

  mbps_fifo #(
    .DEPTH(mbps_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_data),
    .full    (full),
    .rd_en   (take),
    .rd_data (head_data),
    .nonempty(head_valid)
  );

  mbps_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head_valid  (head_valid),
    .head_data   (head_data),
    .take        (take),
    .pop         (pop),
    .empty       (empty),
    .found       (found),
    .match_offset(match_offset)
  );

endmodule

// ===== rtl/core/mbps_front.sv =====
`include "masked_byte_pattern_scan_assert.svh"

module mbps_front #(
  parameter int PATTERN_MAX = mbps_pkg::PATTERN_MAX_DEF,
  parameter int OFFSET_BITS = mbps_pkg::OFFSET_BITS_DEF,
  localparam int LEN_W = $clog2(PATTERN_MAX + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               data_byte,
  input  logic                     last_byte,
  input  logic [PATTERN_MAX*8-1:0] pattern,
  input  logic [PATTERN_MAX-1:0]   care,
  input  logic [LEN_W-1:0]         len,
  output logic                     res_push,
  output mbps_pkg::result_t        res_data
);

  localparam int SEEN_W = mbps_pkg::SEEN_W;
  localparam int WIN_D  = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
  localparam logic [SEEN_W-1:0] SEEN_MAX = '1;
  localparam logic [SEEN_W-1:0] OFF_SAT =
    (OFFSET_BITS >= SEEN_W) ? '1 : SEEN_W'((64'd1 << OFFSET_BITS) - 64'd1);

  logic [7:0]               window [WIN_D];
  logic [SEEN_W-1:0]        bytes_seen, bytes_seen_next;
  logic                     match_reported, match_reported_next;

  logic [PATTERN_MAX*8-1:0] hist;
  logic [PATTERN_MAX*8-1:0] rev_pat, al_pat;
  logic [PATTERN_MAX-1:0]   rev_care, al_care, byte_ok;
  logic [LEN_W-1:0]         shift;
  logic                     eligible, hit;
  logic [SEEN_W-1:0]        off_full, off_sat;

  // hist byte 0 is the incoming byte, byte i the one seen i bytes before
  assign hist[7:0] = data_byte;
  for (genvar i = 1; i < PATTERN_MAX; i++) begin : g_hist
    assign hist[i*8 +: 8] = window[i-1];
  end

  // Align pattern byte len-1-i with hist byte i: reverse, then shift down.
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_rev
    assign rev_pat[k*8 +: 8] = pattern[(PATTERN_MAX-1-k)*8 +: 8];
    assign rev_care[k]       = care[PATTERN_MAX-1-k];
  end

  assign shift   = LEN_W'(PATTERN_MAX) - len;
  assign al_pat  = rev_pat >> {shift, 3'b000};
  assign al_care = rev_care >> shift;

  for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_cmp
    assign byte_ok[i] = !al_care[i] || (hist[i*8 +: 8] == al_pat[i*8 +: 8]);
  end

  assign hit      = &byte_ok;
  assign eligible = !match_reported && (bytes_seen >= SEEN_W'(len) - 1'b1);
  assign off_full = bytes_seen - (SEEN_W'(len) - 1'b1);
  assign off_sat  = (off_full > OFF_SAT) ? OFF_SAT : off_full;

  always_comb begin
    res_push              = 1'b0;
    res_data.found        = 1'b0;
    res_data.match_offset = '0;
    bytes_seen_next       = bytes_seen;
    match_reported_next   = match_reported;
    if (accept) begin
      if (eligible && hit) begin
        res_push              = 1'b1;
        res_data.found        = 1'b1;
        res_data.match_offset = off_sat[mbps_pkg::OFFSET_W-1:0];
        match_reported_next   = 1'b1;
      end else if (last_byte && !match_reported) begin
        res_push = 1'b1;
      end
      if (last_byte) begin
        bytes_seen_next     = '0;
        match_reported_next = 1'b0;
      end else if (bytes_seen != SEEN_MAX) begin
        bytes_seen_next = bytes_seen + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen     <= '0;
      match_reported <= 1'b0;
    end else begin
      bytes_seen     <= bytes_seen_next;
      match_reported <= match_reported_next;
    end
  end

  // Window bytes before the region start are never compared: no reset needed.
  always_ff @(posedge clk) begin
    if (accept && !last_byte) begin
      window[0] <= data_byte;
      for (int i = 1; i < WIN_D; i++) begin
        window[i] <= window[i-1];
      end
    end
  end

  `MBPS_ASSERT(a_one_report, res_push |-> !match_reported, "second report in one region")
  `MBPS_ASSERT(a_region_clear, (accept && last_byte) |=> (bytes_seen == '0 && !match_reported), "region state not cleared")
  `MBPS_ASSERT(a_count_step, (accept && !last_byte && bytes_seen != SEEN_MAX) |=> (bytes_seen == $past(bytes_seen) + 1'b1), "byte count did not advance")

endmodule

// ===== rtl/core/mbps_fifo.sv =====
`include "masked_byte_pattern_scan_assert.svh"

module mbps_fifo #(
  parameter int DEPTH = mbps_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr_en,
  input  mbps_pkg::result_t wr_data,
  output logic              full,
  input  logic              rd_en,
  output mbps_pkg::result_t rd_data,
  output logic              nonempty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  mbps_pkg::result_t slots [DEPTH];
  logic [AW-1:0]     wr_ptr, rd_ptr;
  logic [AW:0]       count;
  logic              do_wr, do_rd;

  assign full     = (count == (AW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && nonempty;
  assign rd_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  `MBPS_ASSERT(a_no_overflow, !(wr_en && full), "request pushed into a full queue")
  `MBPS_ASSERT(a_count_range, count <= (AW+1)'(DEPTH), "queue count out of range")
  `MBPS_ASSERT(a_fill, (do_wr && !do_rd) |=> (count == $past(count) + 1'b1), "queue count did not grow")

endmodule

// ===== rtl/core/mbps_back.sv =====
module mbps_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            head_valid,
  input  mbps_pkg::result_t               head_data,
  output logic                            take,
  input  logic                            pop,
  output logic                            empty,
  output logic                            found,
  output logic [mbps_pkg::OFFSET_W-1:0]   match_offset
);

  logic out_valid;

  // Load the next result when the output register is free or being drained.
  assign take  = head_valid && (!out_valid || pop);
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      found        <= head_data.found;
      match_offset <= head_data.match_offset;
    end
  end

endmodule

// ===== tb/sv/masked_byte_pattern_scan_tb.sv =====
module masked_byte_pattern_scan_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW_DEPTH = mbps_pkg::PATTERN_MAX_DEF - 1;
  localparam longint unsigned OFFSET_LIMIT = (64'd1 << mbps_pkg::OFFSET_BITS_DEF) - 1;
  localparam int SETTLE_CYCLES = 4;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_BYTES = 200;
  localparam int PHASE_COUNT = 8;

  // Mirrors the scanner: register copies, the byte history of the current
  // region, and the reports still owed by the block.
  class match_tracker;
    logic [mbps_pkg::CFG_DATA_W-1:0] pattern_word [mbps_pkg::PAT_WORDS];
    logic [mbps_pkg::CARE_W-1:0]     care;
    logic [mbps_pkg::LEN_CFG_W-1:0]  length_reg;
    logic [7:0]                      recent [WINDOW_DEPTH];
    logic [mbps_pkg::SEEN_W-1:0]     seen;
    bit                              reported;
    mbps_pkg::result_t               pending_reports [$];
    int unsigned                     mismatches;

    function new();
      int unsigned w;
      for (w = 0; w < mbps_pkg::PAT_WORDS; w++) pattern_word[w] = '0;
      care = '0;
      length_reg = mbps_pkg::LEN_CFG_W'(1);
      mismatches = 0;
      clear_region();
    endfunction

    function void clear_region();
      int unsigned k;
      for (k = 0; k < WINDOW_DEPTH; k++) recent[k] = '0;
      seen = '0;
      reported = 1'b0;
    endfunction

    function void load_register(logic [mbps_pkg::CFG_INDEX_W-1:0] idx,
                                logic [mbps_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mbps_pkg::REG_PATTERN_A, mbps_pkg::REG_PATTERN_B, mbps_pkg::REG_PATTERN_C,
        mbps_pkg::REG_PATTERN_D, mbps_pkg::REG_PATTERN_E,
        mbps_pkg::REG_PATTERN_F: pattern_word[idx] = value;
        mbps_pkg::REG_CARE: care = value[mbps_pkg::CARE_W-1:0];
        mbps_pkg::REG_LENGTH: length_reg = value[mbps_pkg::LEN_CFG_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned active_length();
      if (length_reg == 0) return 1;
      if (length_reg > mbps_pkg::PATTERN_MAX_DEF) return mbps_pkg::PATTERN_MAX_DEF;
      return 32'(length_reg);
    endfunction

    function logic [7:0] pattern_byte(int unsigned j);
      return pattern_word[j / 8][(j % 8) * 8 +: 8];
    endfunction

    function void scan_byte(logic [7:0] value, logic last);
      int unsigned n, j;
      longint unsigned pos, start;
      bit hit;
      logic [7:0] b;
      mbps_pkg::result_t r;
      n = active_length();
      pos = seen;
      if (!reported && pos + 1 >= n) begin
        hit = 1'b1;
        for (j = 0; j < n; j++) begin
          b = (j == n - 1) ? value : recent[n - 2 - j];
          if (care[j] && b != pattern_byte(j)) hit = 1'b0;
        end
        if (hit) begin
          start = pos + 1 - n;
          if (start > OFFSET_LIMIT) start = OFFSET_LIMIT;
          r.found = 1'b1;
          r.match_offset = start[mbps_pkg::OFFSET_W-1:0];
          pending_reports.push_back(r);
          reported = 1'b1;
        end
      end
      if (last) begin
        if (!reported) begin
          r.found = 1'b0;
          r.match_offset = '0;
          pending_reports.push_back(r);
        end
        clear_region();
      end else begin
        for (j = WINDOW_DEPTH - 1; j > 0; j--) recent[j] = recent[j - 1];
        recent[0] = value;
        if (seen != '1) seen = seen + 1'b1;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: mismatch: %s", $time, msg);
    endfunction

    function void compare_report(logic f, logic [mbps_pkg::OFFSET_W-1:0] off);
      mbps_pkg::result_t want;
      if (pending_reports.size() == 0) begin
        flag($sformatf("unexpected report found=%0b offset=%0d", f, off));
        return;
      end
      want = pending_reports.pop_front();
      if (f !== want.found)
        flag($sformatf("found: expected %0b, got %0b", want.found, f));
      if (off !== want.match_offset)
        flag($sformatf("match_offset: expected %0d, got %0d", want.match_offset, off));
    endfunction
  endclass

  logic                             clk;
  logic                             rst = 1'b1;
  logic                             push = 1'b0;
  logic                             full;
  logic [7:0]                       data_byte = '0;
  logic                             last_byte = 1'b0;
  logic                             empty;
  logic                             pop = 1'b0;
  logic                             found;
  logic [mbps_pkg::OFFSET_W-1:0]    match_offset;
  logic                             cfg_valid = 1'b0;
  logic                             cfg_ready;
  logic [mbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mbps_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  match_tracker tracker;
  logic [7:0] region_buf [$];
  logic [mbps_pkg::CFG_DATA_W-1:0] cfg_words [mbps_pkg::PAT_WORDS];
  int unsigned bytes_sent = 0;
  int unsigned burst_left = 0;
  int unsigned quiet_cycles = 0;
  int unsigned pop_mode = 0;
  int unsigned pop_mode_left = 0;
  int unsigned pop_hold = 0;

  masked_byte_pattern_scan dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .data_byte(data_byte),
    .last_byte(last_byte),
    .empty(empty),
    .pop(pop),
    .found(found),
    .match_offset(match_offset),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (pop && !empty) tracker.compare_report(found, match_offset);
      if (push && !full) tracker.scan_byte(data_byte, last_byte);
      if ((pop && !empty) || (push && !full) || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("masked_byte_pattern_scan test failed");
    $finish;
  end

  // Receiver: switch between always ready, coin flips and long holds.
  always @(negedge clk) begin
    if (pop_mode_left == 0) begin
      pop_mode = $urandom_range(0, 2);
      pop_mode_left = $urandom_range(50, 300);
    end else begin
      pop_mode_left--;
    end
    case (pop_mode)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(0, 1));
      default: begin
        if (pop_hold == 0) pop_hold = $urandom_range(1, 30);
        pop_hold--;
        pop <= (pop_hold == 0);
      end
    endcase
  end

  task automatic send_byte(logic [7:0] value, logic last);
    @(negedge clk);
    push <= 1'b1;
    data_byte <= value;
    last_byte <= last;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  task automatic pace();
    int unsigned gap;
    if (burst_left != 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk);
        push <= 1'b0;
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                               : $urandom_range(1, 40);
    end
  endtask

  task automatic send_region();
    int unsigned i;
    for (i = 0; i < region_buf.size(); i++) begin
      send_byte(region_buf[i], i == region_buf.size() - 1);
      pace();
    end
  endtask

  // Hold requests until every owed report has come out, then let the pipe settle.
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (tracker.pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [mbps_pkg::CFG_INDEX_W-1:0] idx,
                           logic [mbps_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    tracker.load_register(idx, value);
  endtask

  task automatic apply_config(logic [mbps_pkg::CFG_DATA_W-1:0] care_data,
                              logic [mbps_pkg::CFG_DATA_W-1:0] len_data);
    wait_idle();
    write_reg(mbps_pkg::REG_PATTERN_A, cfg_words[0]);
    write_reg(mbps_pkg::REG_PATTERN_B, cfg_words[1]);
    write_reg(mbps_pkg::REG_PATTERN_C, cfg_words[2]);
    write_reg(mbps_pkg::REG_PATTERN_D, cfg_words[3]);
    write_reg(mbps_pkg::REG_PATTERN_E, cfg_words[4]);
    write_reg(mbps_pkg::REG_PATTERN_F, cfg_words[5]);
    write_reg(mbps_pkg::REG_CARE, care_data);
    write_reg(mbps_pkg::REG_LENGTH, len_data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic program_phase(int unsigned k);
    logic [mbps_pkg::CARE_W-1:0] care_bits;
    int unsigned len, w;
    for (w = 0; w < mbps_pkg::PAT_WORDS; w++) cfg_words[w] = {$urandom, $urandom};
    care_bits = {$urandom, 16'($urandom)};
    len = $urandom_range(2, 47);
    case (k)
      0: begin
        care_bits = '1;
        len = 1;
      end
      1: begin
        for (w = 0; w < mbps_pkg::PAT_WORDS; w++) cfg_words[w] = w[0] ? '0 : '1;
        care_bits = '1;
        len = mbps_pkg::PATTERN_MAX_DEF;
      end
      2: len = 0;
      3: len = 63;
      4: care_bits = '0;
      6: begin
        care_bits = '1;
        len = $urandom_range(2, 8);
      end
      default: ;
    endcase
    apply_config({16'($urandom), care_bits}, {$urandom, 26'($urandom), 6'(len)});
  endtask

  // Random region, usually with the pattern planted somewhere and now and
  // then with one byte of it flipped to make a near miss.
  task automatic random_region();
    int unsigned n, rlen, at, j, pick;
    n = tracker.active_length();
    if ($urandom_range(0, 29) == 0) rlen = $urandom_range(100, 400);
    else rlen = $urandom_range(1, n + 24);
    region_buf.delete();
    repeat (rlen) region_buf.push_back(8'($urandom));
    if (rlen >= n && $urandom_range(0, 3) != 0) begin
      at = $urandom_range(0, rlen - n);
      for (j = 0; j < n; j++)
        if (tracker.care[j] || $urandom_range(0, 1) == 1)
          region_buf[at + j] = tracker.pattern_byte(j);
      if ($urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, n - 1);
        region_buf[at + pick] = region_buf[at + pick] ^ 8'(1 << $urandom_range(0, 7));
      end
    end
    send_region();
  endtask

  initial begin
    int unsigned k, phase_start;
    tracker = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset defaults: one-byte wildcard, so every region hits at its first byte.
    region_buf = '{8'hAB, 8'hCD};
    send_region();
    region_buf = '{8'h00};
    send_region();

    // Three-byte pattern 00 FF '?', last byte a wildcard; upper data bits dropped.
    cfg_words[0] = 64'h3F_FF_00;
    for (k = 1; k < mbps_pkg::PAT_WORDS; k++) cfg_words[k] = '0;
    apply_config(64'hFFFF_0000_0000_0003, 64'hFFFF_FFFF_FFFF_FFC3);
    region_buf = '{8'h00, 8'hFF};
    send_region();
    region_buf = '{8'h12, 8'h00, 8'hFF, 8'h55, 8'h00, 8'hFF, 8'h3F, 8'h99};
    send_region();
    region_buf = '{8'h00, 8'hFF, 8'hFF};
    send_region();
    region_buf = '{8'h00, 8'hFE, 8'h3F};
    send_region();
    region_buf = '{8'hFF};
    send_region();

    for (k = 0; k < PHASE_COUNT; k++) begin
      program_phase(k);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        random_region();
        if ($urandom_range(0, 24) == 0) wait_idle();
      end
    end

    wait_idle();
    if (tracker.mismatches == 0) $display("masked_byte_pattern_scan test passed");
    else $display("masked_byte_pattern_scan test failed");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/mbps_pkg.sv
rtl/core/mbps_front.sv
rtl/core/mbps_fifo.sv
rtl/core/mbps_back.sv
rtl/core/masked_byte_pattern_scan.sv
tb/sv/masked_byte_pattern_scan_tb.sv
